[sv/bdt_pkg.sv]
// Shared types and constants for the button debounce tracker.
// Holds button codes, register indexes, D-pad angle limits and the result type.
// No dependencies.
`default_nettype none

package bdt_pkg;

  localparam int unsigned BUTTON_COUNT = 16;
  localparam int unsigned BTN_W        = 4;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned STAMP_W      = 32;
  localparam int unsigned CFG_W        = 64;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned GROUP_COUNT  = 4;

  // Button codes
  localparam logic [BTN_W-1:0] BTN_LAST_DIGITAL = 4'd9;
  localparam logic [BTN_W-1:0] BTN_LEFT_TRIGGER = 4'd10;
  localparam logic [BTN_W-1:0] BTN_RIGHT_TRIGGER = 4'd11;

  // D-pad direction codes, from the low two bits of buttons 12-15
  localparam logic [1:0] PAD_UP    = 2'd0;
  localparam logic [1:0] PAD_RIGHT = 2'd1;
  localparam logic [1:0] PAD_DOWN  = 2'd2;
  localparam logic [1:0] PAD_LEFT  = 2'd3;

  // D-pad sector limits in degrees
  localparam logic signed [9:0] PAD_UP_END    = 10'sd45;
  localparam logic signed [9:0] PAD_RIGHT_END = 10'sd135;
  localparam logic signed [9:0] PAD_DOWN_END  = 10'sd225;
  localparam logic signed [9:0] PAD_LEFT_END  = 10'sd315;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_A = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_B = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_C = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_D = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLR_A = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLR_B = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLR_C = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CLR_D = 4'd7;

  // One result item
  typedef struct packed {
    logic raw_active;
    logic raw_pressed;
    logic raw_released;
    logic debounced_active;
    logic debounced_pressed;
    logic debounced_released;
  } result_t;

  // Decode one D-pad direction from a signed angle
  function automatic logic pad_dir(input logic signed [9:0] a, input logic [1:0] dir);
    logic hit;
    case (dir)
      PAD_UP:    hit = (a >= 10'sd0 && a <= PAD_UP_END) || a >= PAD_LEFT_END;
      PAD_RIGHT: hit = a >= PAD_UP_END && a <= PAD_RIGHT_END;
      PAD_DOWN:  hit = a >= PAD_RIGHT_END && a <= PAD_DOWN_END;
      default:   hit = a >= PAD_DOWN_END && a <= PAD_LEFT_END;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

[sv/button_debounce_tracker.sv]
// Results go to the output register, or to the skid register if it is held; one
// sample per cycle while the skid is empty. The per-button state read, compare,
// 32-bit elapsed-time subtract and state write all complete in the accept cycle.
// A two-entry output buffer (result register plus skid register) lets a sample
// be accepted while one result waits; input stalls only while the skid is full.
// Synchronous reset clears levels, stamps, time registers and buffer valids.
`default_nettype none

module button_debounce_tracker
  import bdt_pkg::*;
#(
  parameter int unsigned TRIGGER_THRESHOLD = 32768
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // sample channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BTN_W-1:0]     button_index,
  input  wire logic                 digital_level,
  input  wire logic [15:0]          left_trigger,
  input  wire logic [15:0]          right_trigger,
  input  wire logic signed [9:0]    pad_angle,
  input  wire logic                 connected,
  input  wire logic [STAMP_W-1:0]   now_ms,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      raw_active,
  output logic                      raw_pressed,
  output logic                      raw_released,
  output logic                      debounced_active,
  output logic                      debounced_pressed,
  output logic                      debounced_released,
  // configuration channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam logic [15:0] THRESHOLD = 16'(TRIGGER_THRESHOLD);

  logic [CFG_W-1:0]   act_times [GROUP_COUNT];
  logic [CFG_W-1:0]   clr_times [GROUP_COUNT];
  logic [BUTTON_COUNT-1:0] raw_levels;
  logic [BUTTON_COUNT-1:0] debounced_levels;
  logic [STAMP_W-1:0] transition_stamps [BUTTON_COUNT];

  result_t out_res;
  result_t skid_res;
  logic    skid_valid;

  logic    in_xfer;
  logic    out_xfer;
  logic    new_level;
  logic    prev_level;
  logic    deb_level;
  logic    stamp_load;
  logic    press_ok;
  logic    release_ok;
  logic [STAMP_W-1:0] stamp_now;
  logic [STAMP_W-1:0] elapsed;
  logic [TIME_W-1:0]  act_time;
  logic [TIME_W-1:0]  clr_time;
  logic    deb_next;
  result_t res_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  // Raw level from the button's source
  always_comb begin
    if (button_index <= BTN_LAST_DIGITAL) begin
      new_level = digital_level;
    end else if (button_index == BTN_LEFT_TRIGGER) begin
      new_level = left_trigger > THRESHOLD;
    end else if (button_index == BTN_RIGHT_TRIGGER) begin
      new_level = right_trigger > THRESHOLD;
    end else begin
      new_level = pad_dir(pad_angle, button_index[1:0]);
    end
  end

  // Debounce decision for the addressed button
  always_comb begin
    prev_level = raw_levels[button_index];
    deb_level  = debounced_levels[button_index];
    stamp_load = (prev_level == deb_level) && (new_level != deb_level);
    stamp_now  = stamp_load ? now_ms : transition_stamps[button_index];
    elapsed    = now_ms - stamp_now;
    act_time   = act_times[button_index[3:2]][{button_index[1:0], 4'b0000} +: TIME_W];
    clr_time   = clr_times[button_index[3:2]][{button_index[1:0], 4'b0000} +: TIME_W];
    press_ok   = (new_level != deb_level) && new_level
                 && (elapsed >= {{(STAMP_W-TIME_W){1'b0}}, act_time});
    release_ok = (new_level != deb_level) && !new_level
                 && (elapsed >= {{(STAMP_W-TIME_W){1'b0}}, clr_time});
    deb_next   = press_ok ? 1'b1 : (release_ok ? 1'b0 : deb_level);

    if (connected) begin
      res_next.raw_active         = new_level;
      res_next.raw_pressed        = new_level && !prev_level;
      res_next.raw_released       = !new_level && prev_level;
      res_next.debounced_active   = deb_next;
      res_next.debounced_pressed  = press_ok;
      res_next.debounced_released = release_ok;
    end else begin
      res_next = '0;
    end
  end

  // Hold the time registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
        act_times[g] <= '0;
        clr_times[g] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACT_A: act_times[0] <= cfg_data;
        CFG_ACT_B: act_times[1] <= cfg_data;
        CFG_ACT_C: act_times[2] <= cfg_data;
        CFG_ACT_D: act_times[3] <= cfg_data;
        CFG_CLR_A: clr_times[0] <= cfg_data;
        CFG_CLR_B: clr_times[1] <= cfg_data;
        CFG_CLR_C: clr_times[2] <= cfg_data;
        CFG_CLR_D: clr_times[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Update the per-button state on a connected transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_levels       <= '0;
      debounced_levels <= '0;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        transition_stamps[b] <= '0;
      end
    end else if (in_xfer && connected) begin
      raw_levels[button_index]        <= new_level;
      debounced_levels[button_index]  <= deb_next;
      transition_stamps[button_index] <= stamp_now;
    end
  end

  // Advance the output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_res   <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res_next;
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  assign raw_active         = out_res.raw_active;
  assign raw_pressed        = out_res.raw_pressed;
  assign raw_released       = out_res.raw_released;
  assign debounced_active   = out_res.debounced_active;
  assign debounced_pressed  = out_res.debounced_pressed;
  assign debounced_released = out_res.debounced_released;

`ifndef SYNTHESIS
  // The skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  // A debounced edge never comes without the matching level
  a_press_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.debounced_pressed) |-> out_res.debounced_active)
    else $error("debounced press without active level");

  a_release_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.debounced_released) |-> !out_res.debounced_active)
    else $error("debounced release with active level");

  // A disconnected sample leaves button state untouched
  a_disconnected_hold: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !connected) |=> ($stable(raw_levels) && $stable(debounced_levels)))
    else $error("disconnected sample changed button state");
`endif

endmodule

`default_nettype wire
